>>> hdl/rlesp_pkg.sv
// ----------------------------------------------------------------------------
// rlesp_pkg
// shared constants, phase codes and item structs of the scan line parser
// ----------------------------------------------------------------------------
package rlesp_pkg;

	localparam int STORE_BYTES = 16384;
	localparam int ROOM_AFTER_LINE = 64;

	localparam logic [14:0] CAP_MAX = 15'(STORE_BYTES);
	localparam logic [14:0] CAP_RESET = 15'd12000;
	localparam logic [15:0] ROOM = 16'(ROOM_AFTER_LINE);

	// parse phase codes
	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_EXTENT = 3'd1;
	localparam logic [2:0] PH_LENGTH = 3'd2;
	localparam logic [2:0] PH_OFFSET = 3'd3;
	localparam logic [2:0] PH_RAW = 3'd4;
	localparam logic [2:0] PH_HEADER = 3'd5;
	localparam logic [2:0] PH_REPEAT = 3'd6;
	localparam logic [2:0] PH_LITERAL = 3'd7;

	// result kinds
	localparam logic [2:0] KIND_IGNORED = 3'd0;
	localparam logic [2:0] KIND_EXTENT = 3'd1;
	localparam logic [2:0] KIND_LENGTH = 3'd2;
	localparam logic [2:0] KIND_OFFSET = 3'd3;
	localparam logic [2:0] KIND_RAW = 3'd4;
	localparam logic [2:0] KIND_HEADER = 3'd5;
	localparam logic [2:0] KIND_REPEAT = 3'd6;
	localparam logic [2:0] KIND_LITERAL = 3'd7;

	// status codes
	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_RAW_LONG = 2'd1;
	localparam logic [1:0] STAT_OVERFLOW = 2'd2;

	// configuration register byte address bit above the word offset
	localparam logic REG_CAPACITY = 1'b0;

	localparam logic CMD_BEGIN = 1'b0;

	typedef struct packed {
		logic [2:0] phase;
		logic [14:0] write_pointer;
		logic [2:0] field_index;
		logic [7:0] low_hold;
		logic [14:0] pixels_total;
		logic [15:0] pixels_done;
		logic coded;
		logic [6:0] run_left;
		logic [3:0][15:0] extent;
		logic [1:0] status;
	} parse_state_t;

	typedef struct packed {
		logic store_valid;
		logic [13:0] store_address;
		logic [7:0] store_value;
		logic [2:0] item_kind;
		logic frame_done;
		logic [14:0] frame_length;
		logic [3:0][15:0] extent;
		logic [1:0] status;
	} parse_result_t;

endpackage

>>> hdl/rlesp_step.sv
// ----------------------------------------------------------------------------
// rlesp_step
// next state and result of the parser for one stream item
// ----------------------------------------------------------------------------
module rlesp_step (
	input logic command,
	input logic [7:0] data_byte,
	input logic [14:0] capacity,
	input rlesp_pkg::parse_state_t st,
	output rlesp_pkg::parse_state_t nx,
	output rlesp_pkg::parse_result_t res
);

	logic overflow;
	logic [14:0] wp_inc;
	logic fin_stop;
	logic raw_long;
	logic [15:0] pd_inc;
	logic [15:0] pd_run;
	logic [6:0] run_dec;
	logic [15:0] word;
	logic stored;
	logic done;
	logic [2:0] kind;

	// phase after a line has possibly ended
	function automatic logic [2:0] end_phase(input logic [15:0] pd, input logic [14:0] tot,
			input logic stop);
		logic [2:0] ph;
		if (pd >= {1'b0, tot}) begin
			ph = stop ? rlesp_pkg::PH_IDLE : rlesp_pkg::PH_LENGTH;
		end else begin
			ph = rlesp_pkg::PH_HEADER;
		end
		return ph;
	endfunction

	assign overflow = st.write_pointer >= capacity;
	assign wp_inc = st.write_pointer + 15'd1;
	assign fin_stop = ({1'b0, wp_inc} + rlesp_pkg::ROOM) > {1'b0, capacity};
	assign raw_long = ({2'b00, wp_inc} + {2'b00, st.pixels_total}) > {2'b00, capacity};
	assign pd_inc = st.pixels_done + 16'd1;
	assign pd_run = st.pixels_done + {9'd0, st.run_left};
	assign run_dec = st.run_left - 7'd1;
	assign word = {data_byte, st.low_hold};

	always_comb begin
		nx = st;
		stored = 1'b0;
		done = 1'b0;
		kind = rlesp_pkg::KIND_IGNORED;
		if (command == rlesp_pkg::CMD_BEGIN) begin
			nx = '0;
			nx.phase = rlesp_pkg::PH_EXTENT;
		end else begin
			unique case (st.phase)
				rlesp_pkg::PH_EXTENT: begin
					kind = rlesp_pkg::KIND_EXTENT;
					if (!st.field_index[0]) begin
						nx.low_hold = data_byte;
					end else begin
						nx.extent[st.field_index[2:1]] = word;
					end
					nx.field_index = st.field_index + 3'd1;
					if (st.field_index == 3'd7) begin
						nx.phase = rlesp_pkg::PH_LENGTH;
					end
				end
				rlesp_pkg::PH_LENGTH, rlesp_pkg::PH_OFFSET, rlesp_pkg::PH_RAW,
				rlesp_pkg::PH_HEADER, rlesp_pkg::PH_REPEAT, rlesp_pkg::PH_LITERAL: begin
					kind = st.phase;
					if (overflow) begin
						nx.status = rlesp_pkg::STAT_OVERFLOW;
						nx.phase = rlesp_pkg::PH_IDLE;
						done = 1'b1;
					end else begin
						stored = 1'b1;
						nx.write_pointer = wp_inc;
						case (st.phase)
							rlesp_pkg::PH_LENGTH: begin
								if (st.field_index == 3'd0) begin
									nx.low_hold = data_byte;
									nx.field_index = 3'd1;
								end else begin
									nx.field_index = 3'd0;
									if (word == 16'd0) begin
										nx.phase = rlesp_pkg::PH_IDLE;
										done = 1'b1;
									end else begin
										nx.coded = word[0];
										nx.pixels_total = word[15:1];
										nx.pixels_done = 16'd0;
										nx.phase = rlesp_pkg::PH_OFFSET;
									end
								end
							end
							rlesp_pkg::PH_OFFSET: begin
								nx.field_index = st.field_index + 3'd1;
								if (st.field_index == 3'd3) begin
									nx.field_index = 3'd0;
									if (st.coded) begin
										nx.phase = end_phase(st.pixels_done, st.pixels_total,
											fin_stop);
										done = nx.phase == rlesp_pkg::PH_IDLE;
									end else if (raw_long) begin
										nx.status = rlesp_pkg::STAT_RAW_LONG;
										nx.phase = rlesp_pkg::PH_IDLE;
										done = 1'b1;
									end else if (st.pixels_total == 15'd0) begin
										nx.phase = fin_stop ? rlesp_pkg::PH_IDLE
											: rlesp_pkg::PH_LENGTH;
										done = fin_stop;
									end else begin
										nx.phase = rlesp_pkg::PH_RAW;
									end
								end
							end
							rlesp_pkg::PH_RAW: begin
								nx.pixels_done = pd_inc;
								if (pd_inc >= {1'b0, st.pixels_total}) begin
									nx.phase = fin_stop ? rlesp_pkg::PH_IDLE
										: rlesp_pkg::PH_LENGTH;
									done = fin_stop;
								end
							end
							rlesp_pkg::PH_HEADER: begin
								nx.run_left = data_byte[7:1];
								if (data_byte[0]) begin
									nx.phase = rlesp_pkg::PH_REPEAT;
								end else if (data_byte[7:1] != 7'd0) begin
									nx.phase = rlesp_pkg::PH_LITERAL;
								end else begin
									nx.phase = end_phase(st.pixels_done, st.pixels_total,
										fin_stop);
									done = nx.phase == rlesp_pkg::PH_IDLE;
								end
							end
							rlesp_pkg::PH_REPEAT: begin
								nx.pixels_done = pd_run;
								nx.run_left = 7'd0;
								nx.phase = end_phase(pd_run, st.pixels_total, fin_stop);
								done = nx.phase == rlesp_pkg::PH_IDLE;
							end
							default: begin
								nx.pixels_done = pd_inc;
								nx.run_left = run_dec;
								if (run_dec == 7'd0) begin
									nx.phase = end_phase(pd_inc, st.pixels_total, fin_stop);
									done = nx.phase == rlesp_pkg::PH_IDLE;
								end
							end
						endcase
					end
				end
				default: begin
					nx.phase = rlesp_pkg::PH_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		res.store_valid = stored;
		res.store_address = stored ? st.write_pointer[13:0] : 14'd0;
		res.store_value = stored ? data_byte : 8'd0;
		res.item_kind = kind;
		res.frame_done = done;
		res.frame_length = nx.write_pointer;
		res.extent = nx.extent;
		res.status = nx.status;
	end

endmodule

>>> hdl/rle_scanline_shape_parser_unit.sv
// ----------------------------------------------------------------------------
// rle_scanline_shape_parser_unit
// sprite frame stream parser: one result item per input byte, with store writes
// ----------------------------------------------------------------------------
// pipeline: input register, combinational parse step, then result register
// throughput: one item per cycle while the result register is empty or out_ready is high;
// otherwise the item is held in the input register and in_ready drops
// reset: asynchronous, no frame open, counters, extents and status cleared,
// capacity 12000
module rle_scanline_shape_parser_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic command,
	input logic [7:0] data_byte,
	output logic out_valid,
	input logic out_ready,
	output logic store_valid,
	output logic [13:0] store_address,
	output logic [7:0] store_value,
	output logic [2:0] item_kind,
	output logic frame_done,
	output logic [14:0] frame_length,
	output logic [15:0] extent_right,
	output logic [15:0] extent_left,
	output logic [15:0] extent_above,
	output logic [15:0] extent_below,
	output logic [1:0] status,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	logic [14:0] capacity_q;
	logic [14:0] cap_eff;
	logic valid_s1;
	logic command_s1;
	logic [7:0] data_byte_s1;
	logic valid_s2;
	rlesp_pkg::parse_result_t res_s2;
	rlesp_pkg::parse_state_t st_q;
	rlesp_pkg::parse_state_t st_nx;
	rlesp_pkg::parse_result_t res_nx;
	logic advance;

	// config port
	assign pready = 1'b1;
	assign prdata = {17'd0, capacity_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= rlesp_pkg::CAP_RESET;
		end else if (psel && penable && pwrite && paddr[2] == rlesp_pkg::REG_CAPACITY) begin
			capacity_q <= pwdata[14:0];
		end
	end

	assign cap_eff = (capacity_q > rlesp_pkg::CAP_MAX) ? rlesp_pkg::CAP_MAX : capacity_q;

	// handshake
	assign advance = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			command_s1 <= command;
			data_byte_s1 <= data_byte;
		end
		if (advance) begin
			res_s2 <= res_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_nx;
		end
	end

	rlesp_step u_step (
		.command(command_s1),
		.data_byte(data_byte_s1),
		.capacity(cap_eff),
		.st(st_q),
		.nx(st_nx),
		.res(res_nx)
	);

	assign out_valid = valid_s2;
	assign store_valid = res_s2.store_valid;
	assign store_address = res_s2.store_address;
	assign store_value = res_s2.store_value;
	assign item_kind = res_s2.item_kind;
	assign frame_done = res_s2.frame_done;
	assign frame_length = res_s2.frame_length;
	assign extent_right = res_s2.extent[0];
	assign extent_left = res_s2.extent[1];
	assign extent_above = res_s2.extent[2];
	assign extent_below = res_s2.extent[3];
	assign status = res_s2.status;

`ifndef SYNTH
	a_addr_follows_length: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.store_valid |->
			({1'b0, res_s2.store_address} + 15'd1) == res_s2.frame_length)
		else $error("store address does not match frame length");

	a_done_closes_frame: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_nx.frame_done |=> st_q.phase == rlesp_pkg::PH_IDLE)
		else $error("frame end did not close the frame");

	a_pointer_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.write_pointer <= rlesp_pkg::CAP_MAX)
		else $error("write pointer beyond store size");

	a_input_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(data_byte_s1) && $stable(command_s1))
		else $error("input stage lost an item");
`endif

endmodule
